/* sv/centered_moving_average_assert.svh */
// assertion macros for the centered moving average block
// no dependencies; defining ASSERT_OFF turns every check into nothing
`ifndef CENTERED_MOVING_AVERAGE_ASSERT_SVH
`define CENTERED_MOVING_AVERAGE_ASSERT_SVH
`ifndef ASSERT_OFF
`define CMA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("centered_moving_average: check failed");
`define CMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("centered_moving_average: check failed");
`else
`define CMA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CMA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/cma_pkg.sv */
// shared constants and state types of the centered moving average block
// no dependencies
package cma_pkg;

  localparam int unsigned SAMPLE_W            = 16;
  localparam int unsigned AVG_W               = 24;
  localparam int unsigned FRAC_W              = 8;
  localparam int unsigned HW_W                = 4;
  localparam logic [HW_W-1:0] HW_RESET        = 4'd1;
  localparam int unsigned MAX_HALF_WINDOW_DEF = 8;
  localparam int unsigned QUEUE_DEPTH_DEF     = 2;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SUM,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_e;

endpackage

/* sv/cma_queue.sv */
// small job queue between the front and the back of the averager
// depends on cma_pkg for the default depth
module cma_queue #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = cma_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push_fire, pop_fire;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push_fire    = push_valid_i && push_ready_o;
  assign pop_fire     = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_fire) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_fire) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_fire && !pop_fire) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_fire && !push_fire) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

/* sv/cma_front.sv */
// front of the averager: takes items, keeps the sample window and the
// half-window register, and sums each result window one tap per cycle
// depends on cma_pkg and centered_moving_average_assert.svh
`include "centered_moving_average_assert.svh"

module cma_front #(
  parameter int unsigned MaxHalfWindow = cma_pkg::MAX_HALF_WINDOW_DEF,
  localparam int unsigned Depth = 2 * MaxHalfWindow + 1,
  localparam int unsigned IdxW  = $clog2(Depth),
  localparam int unsigned CntW  = $clog2(Depth + 1),
  localparam int unsigned SumW  = cma_pkg::SAMPLE_W + IdxW
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cma_pkg::HW_W-1:0]            cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [cma_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                end_of_sequence_i,
  output logic                                job_valid_o,
  input  logic                                job_ready_i,
  output logic signed [SumW-1:0]              job_sum_o,
  output logic [CntW-1:0]                     job_count_o,
  output logic                                job_last_o
);

  cma_pkg::front_state_e state_q, state_d;

  logic [cma_pkg::HW_W-1:0]            hw_q;
  logic signed [cma_pkg::SAMPLE_W-1:0] store_q [Depth];
  logic signed [cma_pkg::SAMPLE_W-1:0] store_d [Depth];
  logic [CntW-1:0]                     seen_q, seen_d;
  logic [CntW-1:0]                     fill_q, fill_d;
  logic [IdxW-1:0]                     centre_q, centre_d;
  logic [IdxW-1:0]                     half_q, half_d;
  logic [IdxW-1:0]                     tap_q, tap_d;
  logic                                flush_q, flush_d;
  logic signed [SumW-1:0]              acc_q, acc_d;

  logic [IdxW-1:0] half_eff, first_centre, left_w, lim_w;
  logic [CntW-1:0] fill_new, first_pos, pos_w;
  logic            in_fire;

  // window bounds of the current result
  assign half_eff     = (32'(hw_q) > MaxHalfWindow) ? IdxW'(MaxHalfWindow) : IdxW'(hw_q);
  assign fill_new     = (seen_q < CntW'(Depth)) ? seen_q + CntW'(1) : seen_q;
  assign first_pos    = fill_new - CntW'(1);
  assign first_centre = (first_pos < CntW'(half_eff)) ? IdxW'(first_pos) : half_eff;
  assign pos_w        = fill_q - CntW'(1) - CntW'(centre_q);
  assign left_w       = (pos_w < CntW'(half_q)) ? IdxW'(pos_w) : half_q;
  assign lim_w        = centre_q + left_w;
  assign in_fire      = in_valid_i && in_ready_o;

  always_comb begin
    store_d[0] = sample_i;
    for (int i = 1; i < Depth; i++) begin
      store_d[i] = store_q[i-1];
    end
  end

  // next state
  always_comb begin
    state_d  = state_q;
    seen_d   = seen_q;
    fill_d   = fill_q;
    centre_d = centre_q;
    half_d   = half_q;
    tap_d    = tap_q;
    flush_d  = flush_q;
    acc_d    = acc_q;
    unique case (state_q)
      cma_pkg::F_IDLE: begin
        if (in_fire) begin
          half_d  = half_eff;
          fill_d  = fill_new;
          flush_d = end_of_sequence_i;
          tap_d   = '0;
          acc_d   = '0;
          if (end_of_sequence_i) begin
            seen_d   = '0;
            centre_d = first_centre;
            state_d  = cma_pkg::F_SUM;
          end else begin
            seen_d   = fill_new;
            centre_d = half_eff;
            if (fill_new > CntW'(half_eff)) begin
              state_d = cma_pkg::F_SUM;
            end
          end
        end
      end
      cma_pkg::F_SUM: begin
        acc_d = acc_q + SumW'(store_q[tap_q]);
        if (tap_q == lim_w) begin
          state_d = cma_pkg::F_PUSH;
        end else begin
          tap_d = tap_q + IdxW'(1);
        end
      end
      cma_pkg::F_PUSH: begin
        if (job_ready_i) begin
          if (flush_q && centre_q != '0) begin
            centre_d = centre_q - IdxW'(1);
            tap_d    = '0;
            acc_d    = '0;
            state_d  = cma_pkg::F_SUM;
          end else begin
            state_d = cma_pkg::F_IDLE;
          end
        end
      end
      default: state_d = cma_pkg::F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = (state_q == cma_pkg::F_IDLE);
    job_valid_o = (state_q == cma_pkg::F_PUSH);
    job_sum_o   = acc_q;
    job_count_o = CntW'(lim_w) + CntW'(1);
    job_last_o  = flush_q && (centre_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cma_pkg::F_IDLE;
      seen_q  <= '0;
      hw_q    <= cma_pkg::HW_RESET;
    end else begin
      state_q <= state_d;
      seen_q  <= seen_d;
      if (cfg_we_i) begin
        hw_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fill_q   <= fill_d;
    centre_q <= centre_d;
    half_q   <= half_d;
    tap_q    <= tap_d;
    flush_q  <= flush_d;
    acc_q    <= acc_d;
    if (in_fire) begin
      store_q <= store_d;
    end
  end

  `CMA_ASSERT_IMPL(a_tap_in_window, clk_i, rst_ni, state_q == cma_pkg::F_SUM, tap_q <= lim_w)
  `CMA_ASSERT_NEXT(a_last_job_ends, clk_i, rst_ni, job_valid_o && job_ready_i && job_last_o, state_q == cma_pkg::F_IDLE)

endmodule

/* sv/cma_back.sv */
// back of the averager: divides each window sum, scaled by 256, by its
// sample count one quotient bit per cycle and holds the result for output
// depends on cma_pkg and centered_moving_average_assert.svh
`include "centered_moving_average_assert.svh"

module cma_back #(
  parameter int unsigned MaxHalfWindow = cma_pkg::MAX_HALF_WINDOW_DEF,
  localparam int unsigned Depth = 2 * MaxHalfWindow + 1,
  localparam int unsigned IdxW  = $clog2(Depth),
  localparam int unsigned CntW  = $clog2(Depth + 1),
  localparam int unsigned SumW  = cma_pkg::SAMPLE_W + IdxW,
  localparam int unsigned DivW  = SumW + cma_pkg::FRAC_W,
  localparam int unsigned StepW = $clog2(DivW)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             job_valid_i,
  output logic                             job_ready_o,
  input  logic signed [SumW-1:0]           job_sum_i,
  input  logic [CntW-1:0]                  job_count_i,
  input  logic                             job_last_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [cma_pkg::AVG_W-1:0] average_o,
  output logic                             last_result_o
);

  cma_pkg::back_state_e state_q, state_d;

  logic [DivW-1:0]                  quo_q, quo_d;
  logic [CntW-1:0]                  rem_q, rem_d;
  logic [CntW-1:0]                  divisor_q, divisor_d;
  logic [StepW-1:0]                 step_q, step_d;
  logic                             neg_q, neg_d;
  logic                             last_q, last_d;
  logic                             out_valid_q, out_valid_d;
  logic signed [cma_pkg::AVG_W-1:0] avg_q, avg_d;
  logic                             out_last_q, out_last_d;

  logic signed [DivW-1:0] dividend;
  logic [DivW-1:0]        magnitude, result;
  logic [CntW:0]          trial;
  logic                   fits, load_out;

  assign dividend  = {job_sum_i, {cma_pkg::FRAC_W{1'b0}}};
  assign magnitude = job_sum_i[SumW-1] ? DivW'(-dividend) : DivW'(dividend);
  assign trial     = {rem_q, quo_q[DivW-1]};
  assign fits      = (trial >= {1'b0, divisor_q});
  assign result    = neg_q ? -quo_q : quo_q;
  assign load_out  = (state_q == cma_pkg::B_DONE) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d   = state_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    step_d    = step_q;
    neg_d     = neg_q;
    last_d    = last_q;
    unique case (state_q)
      cma_pkg::B_IDLE: begin
        if (job_valid_i) begin
          quo_d     = magnitude;
          rem_d     = '0;
          divisor_d = job_count_i;
          step_d    = '0;
          neg_d     = job_sum_i[SumW-1];
          last_d    = job_last_i;
          state_d   = cma_pkg::B_DIV;
        end
      end
      cma_pkg::B_DIV: begin
        rem_d  = fits ? CntW'(trial - {1'b0, divisor_q}) : trial[CntW-1:0];
        quo_d  = {quo_q[DivW-2:0], fits};
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(DivW - 1)) begin
          state_d = cma_pkg::B_DONE;
        end
      end
      cma_pkg::B_DONE: begin
        if (load_out) begin
          state_d = cma_pkg::B_IDLE;
        end
      end
      default: state_d = cma_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    job_ready_o   = (state_q == cma_pkg::B_IDLE);
    out_valid_d   = out_valid_q;
    avg_d         = avg_q;
    out_last_d    = out_last_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      avg_d       = result[cma_pkg::AVG_W-1:0];
      out_last_d  = last_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    out_valid_o   = out_valid_q;
    average_o     = avg_q;
    last_result_o = out_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cma_pkg::B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    divisor_q  <= divisor_d;
    step_q     <= step_d;
    neg_q      <= neg_d;
    last_q     <= last_d;
    avg_q      <= avg_d;
    out_last_q <= out_last_d;
  end

  `CMA_ASSERT_IMPL(a_divisor_nonzero, clk_i, rst_ni, state_q == cma_pkg::B_DIV, divisor_q != '0)
  `CMA_ASSERT_IMPL(a_rem_below_divisor, clk_i, rst_ni, state_q == cma_pkg::B_DIV, rem_q < divisor_q)

endmodule

/* sv/centered_moving_average.sv */
// Centered moving average over a marked stream of signed 16-bit samples.
// Input channel: in_valid_i/in_ready_o with sample_i and end_of_sequence_i.
// Output channel: out_valid_o/out_ready_i with average_o (signed, 8 fraction
// bits, truncated toward zero) and last_result_o on the final position.
// half_window is written through cfg_we_i/cfg_wdata_i, by the user only while idle;
// the block does not enforce it. Reset value 1; values above MaxHalfWindow act as
// MaxHalfWindow. An ordinary item gives at most one result; a marked last item
// gives up to half_window+1 results, the final one flagged, and starts a new sequence.
// The front sums each result window one tap per cycle, and the back divides one
// quotient bit per cycle and sets the throughput. An input item is taken again
// once the front has queued all of its sums. Each result goes from the front's
// sum through the queue and the back's divider to the registered output.
// Reset empties the queue, clears the sequence count and restores half_window.
// When the receiver stalls, the result register holds, the back waits with a
// finished quotient, the queue fills, and then the input side stops.
module centered_moving_average #(
  parameter int unsigned MaxHalfWindow = cma_pkg::MAX_HALF_WINDOW_DEF,
  parameter int unsigned QueueDepth    = cma_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cma_pkg::HW_W-1:0]            cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [cma_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                end_of_sequence_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [cma_pkg::AVG_W-1:0]    average_o,
  output logic                                last_result_o
);

  localparam int unsigned Depth = 2 * MaxHalfWindow + 1;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned SumW  = cma_pkg::SAMPLE_W + IdxW;
  localparam int unsigned JobW  = SumW + CntW + 1;

  logic                   fq_valid, fq_ready, qb_valid, qb_ready;
  logic signed [SumW-1:0] f_sum, b_sum;
  logic [CntW-1:0]        f_count, b_count;
  logic                   f_last, b_last;
  logic [JobW-1:0]        push_job, pop_job;

  cma_front #(
    .MaxHalfWindow(MaxHalfWindow)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .sample_i          (sample_i),
    .end_of_sequence_i (end_of_sequence_i),
    .job_valid_o       (fq_valid),
    .job_ready_i       (fq_ready),
    .job_sum_o         (f_sum),
    .job_count_o       (f_count),
    .job_last_o        (f_last)
  );

  assign push_job = {f_sum, f_count, f_last};
  assign b_sum    = pop_job[JobW-1 -: SumW];
  assign b_count  = pop_job[CntW:1];
  assign b_last   = pop_job[0];

  cma_queue #(
    .Width(JobW),
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (push_job),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_data_o   (pop_job)
  );

  cma_back #(
    .MaxHalfWindow(MaxHalfWindow)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (qb_valid),
    .job_ready_o   (qb_ready),
    .job_sum_i     (b_sum),
    .job_count_i   (b_count),
    .job_last_i    (b_last),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .average_o     (average_o),
    .last_result_o (last_result_o)
  );

endmodule

/* dv/centered_moving_average_checker.sv */
// checker for the centered moving average block: watches both channels and the
// window register, predicts each average and compares it field by field
// depends on cma_pkg
module centered_moving_average_checker #(
  parameter int unsigned MaxHalfWindow = cma_pkg::MAX_HALF_WINDOW_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cma_pkg::HW_W-1:0]            cfg_wdata_i,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic signed [cma_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                end_of_sequence_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic signed [cma_pkg::AVG_W-1:0]    average_i,
  input  logic                                last_result_i,
  output int unsigned                         mismatch_count_o,
  output int unsigned                         pending_o,
  output int unsigned                         checked_o
);

  localparam int unsigned Depth = 2 * MaxHalfWindow + 1;

  typedef struct {
    logic signed [cma_pkg::AVG_W-1:0] average;
    logic                             last_result;
  } average_t;

  logic signed [cma_pkg::SAMPLE_W-1:0] history [Depth];
  int unsigned                         seq_count;
  logic [cma_pkg::HW_W-1:0]            half_window;
  average_t                            expected_avg_q [$];

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatch_count_o++;
  endtask

  // mean of the window centred c samples back, truncated toward zero
  function automatic average_t window_mean(int unsigned c, int unsigned h, int unsigned s,
                                           logic last);
    int unsigned left;
    longint      acc;
    longint      quo;
    average_t    r;
    left = (s - 1 - c < h) ? s - 1 - c : h;
    acc = 0;
    for (int unsigned d = 0; d <= c + left && d < Depth; d++) begin
      acc += history[d];
    end
    quo = (acc <<< cma_pkg::FRAC_W) / longint'(c + 1 + left);
    r.average = quo[cma_pkg::AVG_W-1:0];
    r.last_result = last;
    return r;
  endfunction

  task automatic predict_averages(input logic signed [cma_pkg::SAMPLE_W-1:0] value,
                                  input logic eos);
    int unsigned h;
    int unsigned s;
    int unsigned c;
    h = (half_window > MaxHalfWindow) ? MaxHalfWindow : half_window;
    for (int i = Depth - 1; i > 0; i--) begin
      history[i] = history[i-1];
    end
    history[0] = value;
    if (seq_count < Depth) seq_count++;
    s = seq_count;
    if (eos) begin
      // flush every pending position, oldest first
      c = (s - 1 < h) ? s - 1 : h;
      for (int k = int'(c); k >= 0; k--) begin
        expected_avg_q.push_back(window_mean(k, h, s, k == 0));
      end
      seq_count = 0;
    end else if (s > h) begin
      expected_avg_q.push_back(window_mean(h, h, s, 1'b0));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    average_t exp_avg;
    if (!rst_ni) begin
      half_window = cma_pkg::HW_RESET;
      seq_count = 0;
      foreach (history[i]) history[i] = '0;
      expected_avg_q.delete();
    end else begin
      if (cfg_we_i) half_window = cfg_wdata_i;
      if (in_valid_i && in_ready_i) predict_averages(sample_i, end_of_sequence_i);
      if (out_valid_i && out_ready_i) begin
        checked_o++;
        if (expected_avg_q.size() == 0) begin
          report_mismatch($sformatf("average %0d arrived with nothing expected", average_i));
        end else begin
          exp_avg = expected_avg_q.pop_front();
          if (average_i !== exp_avg.average) begin
            report_mismatch($sformatf("average %0d, expected %0d (result %0d)",
                                      average_i, exp_avg.average, checked_o));
          end
          if (last_result_i !== exp_avg.last_result) begin
            report_mismatch($sformatf("last_result %b, expected %b (result %0d)",
                                      last_result_i, exp_avg.last_result, checked_o));
          end
        end
      end
    end
    pending_o = expected_avg_q.size();
  end

endmodule

/* dv/centered_moving_average_test.sv */
// testbench top for the centered moving average block: drives sample
// sequences and window settings, stalls both sides, and gives the verdict
// depends on cma_pkg, centered_moving_average and centered_moving_average_checker
module centered_moving_average_test;

  localparam int unsigned SampleW        = cma_pkg::SAMPLE_W;
  localparam int unsigned HwW            = cma_pkg::HW_W;
  localparam int unsigned AvgW           = cma_pkg::AVG_W;
  localparam int unsigned DrainCycles    = 100;
  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned LimitCycles    = 1_000_000;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [HwW-1:0]            cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic signed [SampleW-1:0] sample_i;
  logic                      end_of_sequence_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [AvgW-1:0]    average_o;
  logic                      last_result_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        hold_request;
  int unsigned items_sent;
  int unsigned sequences_sent;
  int unsigned cfg_writes;

  centered_moving_average i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .sample_i          (sample_i),
    .end_of_sequence_i (end_of_sequence_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .average_o         (average_o),
    .last_result_o     (last_result_o)
  );

  centered_moving_average_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .sample_i          (sample_i),
    .end_of_sequence_i (end_of_sequence_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .average_i         (average_o),
    .last_result_i     (last_result_o),
    .mismatch_count_o  (mismatches),
    .pending_o         (pending),
    .checked_o         (checked)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  initial begin
    #(8 * LimitCycles);
    $display("TB_ERROR");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off when asked
  initial begin
    int unsigned hold_left;
    logic        hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request === 1'b1 && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = LongHoldCycles;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_item(input logic signed [SampleW-1:0] value, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= value;
    end_of_sequence_i <= eos;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
    if (eos) sequences_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_half_window(input logic [HwW-1:0] value);
    settle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_writes++;
  endtask

  function automatic logic signed [SampleW-1:0] random_sample();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return SampleW'($urandom_range(16) - 8);
      default: return SampleW'($urandom);
    endcase
  endfunction

  function automatic logic [HwW-1:0] random_half_window();
    case ($urandom_range(3))
      0: return '0;
      1: return HwW'(cma_pkg::MAX_HALF_WINDOW_DEF);
      2: return '1;
      default: return HwW'($urandom_range(15));
    endcase
  endfunction

  task automatic send_run(input int unsigned len, input logic close);
    for (int unsigned i = 0; i < len; i++) begin
      send_item(random_sample(), close && (i == len - 1));
    end
  endtask

  initial begin
    int unsigned target;
    int unsigned len;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    sample_i <= '0;
    end_of_sequence_i <= 1'b0;
    hold_request <= 1'b0;
    send_idle_pct = 24;
    recv_idle_pct = 87;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset window of one: single-sample sequence, then extremes
    send_item(16'sh7FFF, 1'b1);
    send_item(16'sh8000, 1'b0);
    send_item(16'sh8000, 1'b0);
    send_item(16'sh0001, 1'b0);
    send_item(16'shFFFF, 1'b1);
    // no neighbours
    write_half_window('0);
    send_item(16'sh5555, 1'b0);
    send_item(16'shAAAA, 1'b1);
    // oversized window acts as the largest one
    write_half_window('1);
    for (int i = 0; i < 9; i++) begin
      send_item(i[0] ? 16'sh8000 : 16'sh7FFF, i == 8);
    end
    // window changed in the middle of a sequence
    write_half_window(4'd2);
    send_item(16'sh5555, 1'b0);
    send_item(16'shAAAA, 1'b0);
    send_item(16'sh0003, 1'b0);
    send_item(16'shFFF9, 1'b0);
    write_half_window(4'd5);
    send_item(16'sh1234, 1'b0);
    send_item(16'sh8001, 1'b0);
    send_item(16'sh7FFE, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 24; recv_idle_pct = 87; end
        1: begin send_idle_pct = 87; recv_idle_pct = 24; end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_request <= 1'b1;
        end
      endcase
      target = items_sent + 62;
      while (items_sent < target) begin
        len = ($urandom_range(5) == 0) ? $urandom_range(17, 30) : $urandom_range(1, 12);
        case ($urandom_range(9))
          0: begin
            write_half_window(random_half_window());
            send_run(len, 1'b1);
          end
          1: begin
            send_run(len, 1'b0);
            write_half_window(random_half_window());
            send_run($urandom_range(1, 10), 1'b1);
          end
          default: send_run(len, 1'b1);
        endcase
      end
    end

    settle();
    $display("sent %0d samples in %0d sequences over %0d window settings",
             items_sent, sequences_sent, cfg_writes);
    $display("compared %0d averages, %0d mismatches", checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* centered_moving_average.f */
+incdir+sv
sv/cma_pkg.sv
sv/cma_queue.sv
sv/cma_front.sv
sv/cma_back.sv
sv/centered_moving_average.sv
dv/centered_moving_average_checker.sv
dv/centered_moving_average_test.sv
